/* hw/rtl/hsfc_pkg.sv */
// hsfc_pkg: shared types and constants for the half/single converter
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package hsfc_pkg;
    typedef enum logic {REQ_H2S = 1'b0, REQ_S2H = 1'b1} req_t;
    localparam logic [30:0] SGL_INF     = 31'h7F800000;
    localparam logic [30:0] SGL_HALFMAX = 31'h477FF000;
    localparam logic [30:0] SGL_HMIN    = 31'h38800000;
    localparam logic [30:0] SGL_TINY    = 31'h33000000;
    localparam logic [30:0] SGL_REBIAS  = 31'h38000000;
    localparam logic [14:0] HLF_INF     = 15'h7C00;
    localparam logic [14:0] HLF_QNAN    = 15'h0200;
endpackage
`default_nettype wire

/* hw/rtl/half_single_float_convert.sv */
// half_single_float_convert: binary16 <-> binary32 bit pattern converter
// depends on hsfc_pkg
//
// usage: an input transfer carries req_type, half_in and single_in;
// req_type 0 converts half_in to single_out, 1 converts single_in to
// half_out (round to nearest even). the unused output field reads zero.
// one result transfer per input transfer, in order.
// the input is converted by combinational logic and held in a result
// register; a result is offered in the cycle after its input transfer.
// throughput: one item per cycle while the result is not stalled, set
// by the single register stage between the two channels.
// the input side stays ready while the result stage is empty or is being
// drained in the same cycle, so a stalled result holds its value and
// blocks new transfers only while it waits.
// reset: asynchronous, clears the result valid; no item is in flight.
`timescale 1ns / 1ps
`default_nettype none
module half_single_float_convert
    import hsfc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        req_type,
    input  wire logic [15:0] half_in,
    input  wire logic [31:0] single_in,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [31:0]      single_out,
    output logic [15:0]      half_out
);
    logic        valid_reg;
    logic [31:0] single_reg, single_next;
    logic [15:0] half_reg, half_next;
    logic        take;

    assign in_stall  = valid_reg & out_stall;
    assign take      = in_valid & ~in_stall;
    assign out_valid = valid_reg;
    assign single_out = single_reg;
    assign half_out   = half_reg;

    // half to single
    logic [31:0] h2s;
    logic [4:0]  he;
    logic [9:0]  hm, hm_norm;
    logic [3:0]  lz;
    always_comb
    begin
        he = half_in[14:10];
        hm = half_in[9:0];
        lz = 4'd0;
        for (int i = 0; i < 10; i++)
        begin
            if (hm[i])
                lz = 4'(9 - i);
        end
        hm_norm = hm << (lz + 4'd1);
        if (he == 5'h1F)
            h2s = {half_in[15], 8'hFF, hm, 13'd0};
        else if (he != 5'd0)
            h2s = {half_in[15], 3'd0, he, hm, 13'd0} + {1'b0, 8'd112, 23'd0};
        else if (hm == 10'd0)
            h2s = {half_in[15], 31'd0};
        else
            h2s = {half_in[15], 8'(8'd113 - 8'd1 - {4'd0, lz}), hm_norm, 13'd0};
    end

    // single to half
    logic [15:0] s2h;
    logic [30:0] ax, rb;
    logic [23:0] sm, q, rem, hw, msk;
    logic [4:0]  sh;
    logic [14:0] qn;
    logic        up;
    always_comb
    begin
        ax  = single_in[30:0];
        sm  = {1'b1, single_in[22:0]};
        sh  = 5'(8'd126 - single_in[30:23]);
        q   = sm >> sh;
        msk = (24'd1 << sh) - 24'd1;
        rem = sm & msk;
        hw  = 24'd1 << (sh - 5'd1);
        rb  = ax - SGL_REBIAS;
        qn  = rb[27:13];
        up  = (rb[12:0] > 13'h1000) || (rb[12:0] == 13'h1000 && qn[0]);
        if (ax >= SGL_INF)
            s2h = {single_in[31], HLF_INF | ((ax > SGL_INF) ? HLF_QNAN : 15'd0)};
        else if (ax >= SGL_HALFMAX)
            s2h = {single_in[31], HLF_INF};
        else if (ax < SGL_TINY)
            s2h = {single_in[31], 15'd0};
        else if (ax < SGL_HMIN)
            s2h = {single_in[31], 15'(q + 24'((rem > hw) || (rem == hw && q[0])))};
        else
            s2h = {single_in[31], 15'(qn + 15'(up))};
    end

    always_comb
    begin
        case (req_t'(req_type))
            REQ_H2S:
            begin
                single_next = h2s;
                half_next   = 16'd0;
            end
            default:
            begin
                single_next = 32'd0;
                half_next   = s2h;
            end
        endcase
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (!in_stall)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            single_reg <= single_next;
            half_reg   <= half_next;
        end
    end
endmodule
`default_nettype wire

/* hw/rtl/hsfc_checker.sv */
// hsfc_checker: port-level checks for the converter
// depends on half_single_float_convert ports only
`timescale 1ns / 1ps
`default_nettype none
module hsfc_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_stall,
    input wire logic        req_type,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [31:0] single_out,
    input wire logic [15:0] half_out
);
    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(single_out) && $stable(half_out))
        else $error("result changed under stall");
    // a transfer in yields a result next cycle
    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> out_valid)
        else $error("missing result");
    // input stalls only behind a stalled result
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("spurious input stall");
    // unused half field reads zero after a half-to-single transfer
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && !req_type |=> half_out == 16'd0)
        else $error("half_out not zero");
endmodule

bind half_single_float_convert hsfc_checker u_hsfc_checker (.*);
`default_nettype wire
